@@ rtl/dhc_pkg.sv @@
`timescale 1ns / 1ps

package dhc_pkg;

  localparam int HEIGHT_RANGE = 200;

  localparam logic [7:0] MAX_HEIGHT_RST      = 8'd150;
  localparam logic [7:0] MIN_HEIGHT_RST      = 8'd80;
  localparam logic [9:0] PRESS_THRESHOLD_RST = 10'd500;
  localparam logic [9:0] ABORT_THRESHOLD_RST = 10'd600;
  localparam logic [3:0] DEADBAND_RST        = 4'd2;
  localparam logic [7:0] PRESET_UP_RST       = 8'd100;
  localparam logic [7:0] PRESET_DOWN_RST     = 8'd80;

  localparam logic [9:0] WIN_UP_LO      = 10'd605;
  localparam logic [9:0] WIN_UP_HI      = 10'd615;
  localparam logic [9:0] WIN_DOWN_LO    = 10'd695;
  localparam logic [9:0] WIN_DOWN_HI    = 10'd700;
  localparam logic [9:0] WIN_SEEK_UP_LO = 10'd830;
  localparam logic [9:0] WIN_SEEK_UP_HI = 10'd845;
  localparam logic [9:0] WIN_SEEK_DN_LO = 10'd925;
  localparam logic [9:0] WIN_SEEK_DN_HI = 10'd935;
  localparam logic [9:0] WIN_STORE_LO   = 10'd1005;
  localparam logic [9:0] WIN_STORE_HI   = 10'd1015;

  localparam logic [2:0] CFG_MAX_HEIGHT      = 3'd0;
  localparam logic [2:0] CFG_MIN_HEIGHT      = 3'd1;
  localparam logic [2:0] CFG_PRESS_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_ABORT_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_DEADBAND        = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_SEEK_UP   = 2'd1,
    MODE_SEEK_DOWN = 2'd2,
    MODE_AWAIT     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_NONE        = 3'd0,
    ST_MAX_LIMIT   = 3'd1,
    ST_MIN_LIMIT   = 3'd2,
    ST_REACHED     = 3'd3,
    ST_ABORTED     = 3'd4,
    ST_UP_STORED   = 3'd5,
    ST_DOWN_STORED = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    BTN_NONE,
    BTN_UP,
    BTN_DOWN,
    BTN_SEEK_UP,
    BTN_SEEK_DOWN,
    BTN_STORE
  } btn_t;

  typedef struct packed {
    logic [7:0] height_cm;
    logic [9:0] button_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_up;
    logic       drive_down;
    logic [1:0] mode_now;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] max_height;
    logic [7:0] min_height;
    logic [9:0] press_threshold;
    logic [9:0] abort_threshold;
    logic [3:0] deadband;
  } cfg_t;

endpackage

@@ rtl/desk_height_controller.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// in_       input      in_valid / in_ready       in_item_t  (height_cm, button_level)
// out_      output     out_valid / out_ready     out_item_t (drive_up, drive_down,
//                                                            mode_now, status)
// cfg_      input      cfg_we                    cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ready stays high; its result passes the input and result registers to out_.
// The input register feeds one compare/subtract pass into the result register.
// rst_n (synchronous) loads register defaults, idle mode, presets 100 / 80, drives off.
// With out_ready low the result holds and one more request parks in the input register.

module desk_height_controller
  import dhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_wdata
);

  logic      inq_valid_r;
  in_item_t  inq_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      advance;
  cfg_t      cfg;
  btn_t      btn;
  out_item_t res;

  assign advance  = inq_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !inq_valid_r || advance;

  dhc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dhc_btn_decode u_dec (
    .level (inq_data_r.button_level),
    .btn   (btn)
  );

  dhc_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (inq_data_r),
    .btn     (btn),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.drive_up && out_data.drive_down))
    else $error("both drives on");

  a_reached_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_REACHED || out_data.status == ST_ABORTED))
      |-> (!out_data.drive_up && !out_data.drive_down && out_data.mode_now == MODE_IDLE))
    else $error("seek end left motor running");

  a_stored_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_UP_STORED || out_data.status == ST_DOWN_STORED))
      |-> out_data.mode_now == MODE_IDLE)
    else $error("preset store did not return to idle");

  a_inq_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (inq_valid_r && !advance) |=> (inq_valid_r && $stable(inq_data_r)))
    else $error("parked request lost");

endmodule

@@ rtl/dhc_cfg_regs.sv @@
`timescale 1ns / 1ps

module dhc_cfg_regs
  import dhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_wdata,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_HEIGHT:      cfg_nxt.max_height      = cfg_wdata[7:0];
        CFG_MIN_HEIGHT:      cfg_nxt.min_height      = cfg_wdata[7:0];
        CFG_PRESS_THRESHOLD: cfg_nxt.press_threshold = cfg_wdata;
        CFG_ABORT_THRESHOLD: cfg_nxt.abort_threshold = cfg_wdata;
        CFG_DEADBAND:        cfg_nxt.deadband        = cfg_wdata[3:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_height      <= MAX_HEIGHT_RST;
      cfg_r.min_height      <= MIN_HEIGHT_RST;
      cfg_r.press_threshold <= PRESS_THRESHOLD_RST;
      cfg_r.abort_threshold <= ABORT_THRESHOLD_RST;
      cfg_r.deadband        <= DEADBAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/dhc_btn_decode.sv @@
`timescale 1ns / 1ps

module dhc_btn_decode
  import dhc_pkg::*;
(
  input  logic [9:0] level,
  output btn_t       btn
);

  always_comb begin
    if (level >= WIN_UP_LO && level <= WIN_UP_HI) begin
      btn = BTN_UP;
    end else if (level >= WIN_DOWN_LO && level <= WIN_DOWN_HI) begin
      btn = BTN_DOWN;
    end else if (level >= WIN_SEEK_UP_LO && level <= WIN_SEEK_UP_HI) begin
      btn = BTN_SEEK_UP;
    end else if (level >= WIN_SEEK_DN_LO && level <= WIN_SEEK_DN_HI) begin
      btn = BTN_SEEK_DOWN;
    end else if (level >= WIN_STORE_LO && level <= WIN_STORE_HI) begin
      btn = BTN_STORE;
    end else begin
      btn = BTN_NONE;
    end
  end

endmodule

@@ rtl/dhc_step.sv @@
`timescale 1ns / 1ps

module dhc_step
  import dhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  btn_t      btn,
  input  cfg_t      cfg,
  output out_item_t res
);

  mode_t      mode_r,        mode_nxt;
  logic [7:0] preset_up_r,   preset_up_nxt;
  logic [7:0] preset_down_r, preset_down_nxt;
  logic       up_r,          up_nxt;
  logic       down_r,        down_nxt;
  status_t    status;

  logic [7:0] h;
  logic       pressed;
  logic [7:0] target;
  logic [7:0] diff;
  logic       reached;
  logic       h_below;
  mode_t      seek_mode;

  assign h       = (32'(item.height_cm) > HEIGHT_RANGE) ? 8'd0 : item.height_cm;
  assign pressed = item.button_level > cfg.press_threshold;

  always_comb begin
    if (mode_r == MODE_IDLE) begin
      seek_mode = (btn == BTN_SEEK_UP) ? MODE_SEEK_UP : MODE_SEEK_DOWN;
    end else begin
      seek_mode = mode_r;
    end
  end

  assign target  = (seek_mode == MODE_SEEK_UP) ? preset_up_r : preset_down_r;
  assign h_below = h < target;
  assign diff    = h_below ? (target - h) : (h - target);
  assign reached = (diff < {4'd0, cfg.deadband}) || (diff == 8'd0);

  always_comb begin
    mode_nxt        = mode_r;
    preset_up_nxt   = preset_up_r;
    preset_down_nxt = preset_down_r;
    up_nxt          = up_r;
    down_nxt        = down_r;
    status          = ST_NONE;

    unique case (mode_r)
      MODE_IDLE: begin
        if (!pressed) begin
          up_nxt   = 1'b0;
          down_nxt = 1'b0;
        end else begin
          case (btn)
            BTN_UP: begin
              down_nxt = 1'b0;
              if (h >= cfg.max_height) begin
                up_nxt = 1'b0;
                status = ST_MAX_LIMIT;
              end else begin
                up_nxt = 1'b1;
              end
            end
            BTN_DOWN: begin
              up_nxt = 1'b0;
              if (h <= cfg.min_height) begin
                down_nxt = 1'b0;
                status   = ST_MIN_LIMIT;
              end else begin
                down_nxt = 1'b1;
              end
            end
            BTN_SEEK_UP, BTN_SEEK_DOWN: begin
              if (reached) begin
                up_nxt   = 1'b0;
                down_nxt = 1'b0;
                mode_nxt = MODE_IDLE;
                status   = ST_REACHED;
              end else begin
                up_nxt   = h_below;
                down_nxt = !h_below;
                mode_nxt = seek_mode;
              end
            end
            BTN_STORE: mode_nxt = MODE_AWAIT;
            default:   mode_nxt = MODE_IDLE;
          endcase
        end
      end
      MODE_SEEK_UP, MODE_SEEK_DOWN: begin
        if (item.button_level > cfg.abort_threshold) begin
          up_nxt   = 1'b0;
          down_nxt = 1'b0;
          mode_nxt = MODE_IDLE;
          status   = ST_ABORTED;
        end else if (reached) begin
          up_nxt   = 1'b0;
          down_nxt = 1'b0;
          mode_nxt = MODE_IDLE;
          status   = ST_REACHED;
        end else begin
          up_nxt   = h_below;
          down_nxt = !h_below;
        end
      end
      MODE_AWAIT: begin
        mode_nxt = MODE_IDLE;
        if (btn == BTN_SEEK_UP) begin
          preset_up_nxt = h;
          status        = ST_UP_STORED;
        end else if (btn == BTN_SEEK_DOWN) begin
          preset_down_nxt = h;
          status          = ST_DOWN_STORED;
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      preset_up_r   <= PRESET_UP_RST;
      preset_down_r <= PRESET_DOWN_RST;
      up_r          <= 1'b0;
      down_r        <= 1'b0;
    end else if (step_en) begin
      mode_r        <= mode_nxt;
      preset_up_r   <= preset_up_nxt;
      preset_down_r <= preset_down_nxt;
      up_r          <= up_nxt;
      down_r        <= down_nxt;
    end
  end

  assign res.drive_up   = up_nxt;
  assign res.drive_down = down_nxt;
  assign res.mode_now   = mode_nxt;
  assign res.status     = status;

endmodule
